FILE: rtl/particle_pool_update_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle pool update core
// Simulation-only checks; empty bodies under SYNTH.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_UPDATE_CORE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_CORE_DEFINES_SVH
`ifndef SYNTH
`define PPU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPU_ASSERT_IMPL(label, ante, cons)
`define PPU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared constants and types for the particle pool update core.
// ----------------------------------------------------------------------------
package ppu_pkg;
  localparam int unsigned MaxParticles = 64;
  localparam logic [23:0] Max24        = 24'hFFFFFF;
  localparam logic [16:0] OneQ16       = 17'h10000;
  localparam logic [15:0] GrowthReset  = 16'h8000;

  typedef enum logic {OP_TICK = 1'b0, OP_SPAWN = 1'b1} op_t;
  typedef enum logic {KIND_SLOT = 1'b0, KIND_SPAWN = 1'b1} kind_t;

  // divider control between the core and the alpha divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

FILE: rtl/ppu_div.sv
// ----------------------------------------------------------------------------
// ppu_div
// Restoring divider, one quotient bit per cycle: (age << 16) / life.
// ----------------------------------------------------------------------------
module ppu_div
  import ppu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] age,
  input  logic [23:0] life,
  output div_ctl_t    ctl,
  output logic [16:0] quot
);
  logic [39:0] num_r,  num_nxt;
  logic [24:0] rem_r,  rem_nxt;
  logic [5:0]  cnt_r,  cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [24:0] trial;
  logic [24:0] shifted;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[23:0], num_r[39]};
    trial    = shifted - {1'b0, life};
    if (start) begin
      num_nxt  = {age, 16'h0};
      rem_nxt  = '0;
      cnt_nxt  = 6'd40;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[24]) begin
        rem_nxt = trial;
        num_nxt = {num_r[38:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  // age < life so the quotient stays below 65536
  assign quot      = num_r[16:0];
  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
endmodule

FILE: rtl/particle_pool_update_core.sv
// ----------------------------------------------------------------------------
// particle_pool_update_core
// Fixed pool of particle slots, spawned and advanced with Euler steps.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in_     | in  | tvalid/tready        | tuser=op, tdata=fields
// out_    | out | tvalid/tready/tlast  | tuser=report_kind, tdata=fields
// cfg_    | in  | APB psel/penable     | growth_rate at address 0
// Every item is accepted in idle, and its work starts in the next cycle.
// Spawn: slots are searched in S_SCAN, then the free slot is written (S_SPAWN) and reported.
// Tick: a live slot is read (S_RD), aged (S_AGE), passed through the shared
// multiply/add (S_VY to S_SZ), the alpha divider (one bit per cycle) and write-back
// (S_WB); a dead slot is only read, a slot freed by this tick is read and aged; each report then waits for out_tready.
// No clearing pass: valid bits reset at once.
// The input is not ready while an item is in work; output stalls hold state.
// ----------------------------------------------------------------------------
`include "particle_pool_update_core_defines.svh"
module particle_pool_update_core
  import ppu_pkg::*;
#(
  parameter int unsigned PARTICLES = MaxParticles
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // op
  // dt[15:0] x[47:16] y[79:48] z[111:80] vx[143:112] vy[175:144] vz[207:176]
  // life[231:208] size[255:232] grav[279:256]
  input  logic [279:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,
  output logic         out_tuser,  // report_kind
  // slot[5:0] live[6] x[38:7] y[70:39] z[102:71] size[126:103] fade[143:127]
  // full[144] pad[151:145]
  output logic [151:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int unsigned SW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SPAWN, S_RD, S_AGE, S_VY, S_PX, S_PY, S_PZ, S_SZ,
    S_DIV, S_WB, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] growth_r;
  logic [PARTICLES-1:0] live_r;
  logic [SW-1:0] slot_r;
  logic [15:0] dt_r;
  logic [279:0] item_r;

  // slot memories
  logic [23:0] age_m  [PARTICLES];
  logic [23:0] life_m [PARTICLES];
  logic [23:0] grav_m [PARTICLES];
  logic [23:0] size_m [PARTICLES];
  logic [31:0] px_m [PARTICLES], py_m [PARTICLES], pz_m [PARTICLES];
  logic [31:0] vx_m [PARTICLES], vy_m [PARTICLES], vz_m [PARTICLES];

  // working copy of one slot
  logic [23:0] age_w, life_w, grav_w, size_w;
  logic [31:0] px_w, py_w, pz_w, vx_w, vy_w, vz_w;

  logic        o_valid_r, o_last_r, o_kind_r, o_live_r, o_full_r;
  logic [5:0]  o_slot_r;
  logic [31:0] o_x_r, o_y_r, o_z_r;
  logic [23:0] o_size_r;
  logic [16:0] o_fade_r;

  // shared arithmetic unit: one 32x16 signed multiply, floor shift, saturating add or subtract
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod;
  logic signed [41:0] prod_sh;
  logic signed [32:0] acc;
  logic signed [42:0] sum;
  logic [31:0] sat_out;
  logic        sub_mode;

  always_comb begin
    mul_a = '0;
    acc = '0;
    sub_mode = 1'b0;
    mul_b = {9'b0, dt_r};
    case (state_r)
      S_VY: begin mul_a = {9'b0, grav_w}; acc = {vy_w[31], vy_w}; sub_mode = 1'b1; end
      S_PX: begin mul_a = {vx_w[31], vx_w}; acc = {px_w[31], px_w}; end
      S_PY: begin mul_a = {vy_w[31], vy_w}; acc = {py_w[31], py_w}; end
      S_PZ: begin mul_a = {vz_w[31], vz_w}; acc = {pz_w[31], pz_w}; end
      S_SZ: begin mul_a = {17'b0, growth_r}; acc = {9'b0, size_w}; end
      default: ;
    endcase
    prod    = mul_a * mul_b;
    prod_sh = 42'(prod >>> 16);
    sum = sub_mode ? (43'(acc) - 43'(prod_sh)) : (43'(acc) + 43'(prod_sh));
    if (sum > 43'sd2147483647)       sat_out = 32'h7FFFFFFF;
    else if (sum < -43'sd2147483648) sat_out = 32'h80000000;
    else                             sat_out = sum[31:0];
  end

  logic [24:0] age_sum;
  assign age_sum = {1'b0, age_w} + {9'b0, dt_r};
  logic [23:0] age_new;
  assign age_new = age_sum[24] ? Max24 : age_sum[23:0];
  logic [42:0] size_sum;
  assign size_sum = 43'(sum);
  logic [23:0] size_new;
  assign size_new = (size_sum > 43'(Max24)) ? Max24 : size_sum[23:0];

  div_ctl_t    dctl;
  logic [16:0] quot;
  logic        div_go;
  assign div_go = (state_r == S_SZ);
  ppu_div u_div (.clk, .rst_n, .start(div_go), .age(age_w), .life(life_w),
                 .ctl(dctl), .quot);

  logic        is_last_slot;
  assign is_last_slot = (slot_r == SW'(PARTICLES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= '0;
      growth_r  <= GrowthReset;
      o_valid_r <= 1'b0;
      slot_r    <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        growth_r <= cfg_pwdata[15:0];
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            item_r <= in_tdata;
            dt_r   <= in_tdata[15:0];
            slot_r <= '0;
            state_r <= (op_t'(in_tuser) == OP_SPAWN) ? S_SCAN : S_RD;
          end
        end
        S_SCAN: begin
          if (!live_r[slot_r]) state_r <= S_SPAWN;
          else if (is_last_slot) begin
            o_valid_r <= 1'b1; o_kind_r <= KIND_SPAWN; o_full_r <= 1'b1;
            o_slot_r <= '0; o_live_r <= 1'b0; o_x_r <= '0; o_y_r <= '0;
            o_z_r <= '0; o_size_r <= '0; o_fade_r <= '0; o_last_r <= 1'b1;
            state_r <= S_OUT;
          end else slot_r <= slot_r + SW'(1);
        end
        S_SPAWN: begin
          live_r[slot_r] <= 1'b1;
          px_m[slot_r] <= item_r[47:16];   py_m[slot_r] <= item_r[79:48];
          pz_m[slot_r] <= item_r[111:80];  vx_m[slot_r] <= item_r[143:112];
          vy_m[slot_r] <= item_r[175:144]; vz_m[slot_r] <= item_r[207:176];
          life_m[slot_r] <= item_r[231:208]; size_m[slot_r] <= item_r[255:232];
          grav_m[slot_r] <= item_r[279:256]; age_m[slot_r] <= '0;
          o_valid_r <= 1'b1; o_kind_r <= KIND_SPAWN; o_full_r <= 1'b0;
          o_slot_r <= 6'(slot_r); o_live_r <= 1'b1; o_x_r <= item_r[47:16];
          o_y_r <= item_r[79:48]; o_z_r <= item_r[111:80];
          o_size_r <= item_r[255:232]; o_fade_r <= OneQ16; o_last_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_RD: begin
          age_w <= age_m[slot_r]; life_w <= life_m[slot_r];
          grav_w <= grav_m[slot_r]; size_w <= size_m[slot_r];
          px_w <= px_m[slot_r]; py_w <= py_m[slot_r]; pz_w <= pz_m[slot_r];
          vx_w <= vx_m[slot_r]; vy_w <= vy_m[slot_r]; vz_w <= vz_m[slot_r];
          if (live_r[slot_r]) state_r <= S_AGE;
          else begin
            o_valid_r <= 1'b1; o_kind_r <= KIND_SLOT; o_full_r <= 1'b0;
            o_slot_r <= 6'(slot_r); o_live_r <= 1'b0; o_x_r <= '0; o_y_r <= '0;
            o_z_r <= '0; o_size_r <= '0; o_fade_r <= '0; o_last_r <= is_last_slot;
            state_r <= S_OUT;
          end
        end
        S_AGE: begin
          age_w <= age_new;
          age_m[slot_r] <= age_new;
          if (age_new >= life_w) begin
            live_r[slot_r] <= 1'b0;
            o_valid_r <= 1'b1; o_kind_r <= KIND_SLOT; o_full_r <= 1'b0;
            o_slot_r <= 6'(slot_r); o_live_r <= 1'b0; o_x_r <= '0; o_y_r <= '0;
            o_z_r <= '0; o_size_r <= '0; o_fade_r <= '0; o_last_r <= is_last_slot;
            state_r <= S_OUT;
          end else state_r <= S_VY;
        end
        S_VY: begin vy_w <= sat_out; state_r <= S_PX; end
        S_PX: begin px_w <= sat_out; state_r <= S_PY; end
        S_PY: begin py_w <= sat_out; state_r <= S_PZ; end
        S_PZ: begin pz_w <= sat_out; state_r <= S_SZ; end
        S_SZ: begin size_w <= size_new; state_r <= S_DIV; end
        S_DIV: if (dctl.done) state_r <= S_WB;
        S_WB: begin
          vy_m[slot_r] <= vy_w; px_m[slot_r] <= px_w; py_m[slot_r] <= py_w;
          pz_m[slot_r] <= pz_w; size_m[slot_r] <= size_w;
          o_valid_r <= 1'b1; o_kind_r <= KIND_SLOT; o_full_r <= 1'b0;
          o_slot_r <= 6'(slot_r); o_live_r <= 1'b1; o_x_r <= px_w;
          o_y_r <= py_w; o_z_r <= pz_w; o_size_r <= size_w;
          o_fade_r <= OneQ16 - quot; o_last_r <= is_last_slot;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            o_valid_r <= 1'b0;
            if (o_last_r) state_r <= S_IDLE;
            else begin
              slot_r <= slot_r + SW'(1);
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = o_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = {7'b0, o_full_r, o_fade_r, o_size_r, o_z_r, o_y_r, o_x_r,
                       o_live_r, o_slot_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'b0, growth_r} : 32'b0;

  `PPU_ASSERT_IMPL(a_out_only_in_out, out_tvalid, state_r == S_OUT)
  `PPU_ASSERT_IMPL(a_div_in_div, dctl.busy, state_r == S_DIV)
  `PPU_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast,
                   state_r == S_IDLE && !out_tvalid)
endmodule
